// ===== design/dnf_pkg.sv =====
package dnf_pkg;

    // Decimal digits held by the converter: enough for any 32-bit magnitude
    localparam int NUM_BCD = 10;
    localparam int MAG_W   = 32;
    localparam int CNT_W   = $clog2(MAG_W);
    localparam int WGT_W   = $clog2(NUM_BCD);

    typedef logic [NUM_BCD-1:0][3:0] bcd_digits_t;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_POINT = 8'd46;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_PLUS  = 8'd43;

endpackage

// ===== design/dnf_bcd_conv.sv =====
// Serial binary to BCD converter: one add-3 correction and shift per cycle.
module dnf_bcd_conv
    import dnf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MAG_W-1:0]  mag,
    output logic              done,
    output bcd_digits_t       digits
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MAG_W-1:0]  bin_reg, bin_next;
    bcd_digits_t       bcd_reg, bcd_next;
    bcd_digits_t       adj;
    logic [NUM_BCD*4-1:0] adj_bits;

    // Add 3 to every digit of five or more, then shift in the next binary bit
    always_comb
    begin
        for (int i = 0; i < NUM_BCD; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // Flatten the corrected digits for the shift
    assign adj_bits = adj;

    // Sequence the shifts
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = mag;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
            bcd_next = {adj_bits[NUM_BCD*4-2:0], bin_reg[MAG_W-1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

// ===== design/decimal_number_formatter.sv =====
// Decimal number formatter. Each input beat carries a signed 32-bit value and its
// print options; the block answers with 1 to 12 output beats, one ASCII character
// each (sign, digits, '.'), tagged with row and column, tlast on the final one.
// An item passes through the serial binary-to-BCD converter (one bit per cycle),
// a hand-over of the digits and a state that sizes the digit field; the characters
// then follow at one per cycle while the output is taken at full rate. s_axis_tready
// is low from acceptance until the last character is loaded into the output register.
module decimal_number_formatter
    import dnf_pkg::*;
#(
    parameter int MAX_DIGITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // value[31:0], digit_count[36:32], point_position[41:37], right_align[42],
    // show_plus[43], start_row[44], start_column[50:45], zero fill[55:51]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_char[7:0], out_row[8], out_column[15:9], width_reported[19:16],
    // zero fill[23:20]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // overflow[0]
    output logic        m_axis_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [1:0] PH_SIGN  = 2'd0;
    localparam logic [1:0] PH_DIGIT = 2'd1;
    localparam logic [1:0] PH_POINT = 2'd2;

    localparam logic [3:0] MAX_D = 4'(MAX_DIGITS);

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [WGT_W-1:0]  w_reg, w_next;
    logic [3:0]        d_reg, d_next;
    logic              ovf_reg, ovf_next;
    logic              neg_reg, plus_reg, right_reg, row_reg;
    logic [4:0]        dc_reg, pp_reg;
    logic [6:0]        col_reg, col_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic [6:0]        out_col_reg;
    logic              out_last_reg, out_last_next;
    logic              out_row_reg;
    logic [3:0]        out_width_reg;
    logic              out_ovf_reg;

    logic              accept;
    logic [MAG_W-1:0]  raw;
    logic [MAG_W-1:0]  mag;
    logic              conv_done;
    bcd_digits_t       digits;

    logic [3:0]        sig;
    logic              load;
    logic              final_char;
    logic              pp_hit;
    logic [WGT_W-1:0]  lead_w;
    logic [3:0]        width_rep;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign raw    = s_axis_tdata[31:0];
    assign mag    = raw[MAG_W-1] ? (~raw + 1'b1) : raw;

    dnf_bcd_conv u_conv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mag    (mag),
        .done   (conv_done),
        .digits (digits)
    );

    // Count significant digits of the magnitude
    always_comb
    begin
        sig = 4'd1;
        for (int i = 1; i < NUM_BCD; i++)
        begin
            if (digits[i] != 4'd0)
            begin
                sig = 4'(i + 1);
            end
        end
    end

    assign lead_w    = WGT_W'(d_reg - 4'd1);
    assign pp_hit    = !pp_reg[4] && (pp_reg[3:0] == 4'(w_reg));
    assign width_rep = d_reg + {3'd0, !pp_reg[4]};
    assign load      = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    // Pick the character at the current position and detect the final one
    always_comb
    begin
        out_char_next = CH_ZERO;
        final_char    = 1'b0;
        unique case (phase_reg)
            PH_SIGN:
            begin
                out_char_next = (right_reg || neg_reg) ? CH_MINUS : CH_PLUS;
                final_char    = right_reg;
            end
            PH_DIGIT:
            begin
                if ((w_reg == lead_w) && ovf_reg)
                    out_char_next = CH_NINE;
                else
                    out_char_next = CH_ZERO + {4'd0, digits[w_reg]};
                if (right_reg)
                    final_char = (w_reg == lead_w) && !neg_reg;
                else
                    final_char = (w_reg == '0) && !pp_hit;
            end
            PH_POINT:
            begin
                out_char_next = CH_POINT;
                final_char    = !right_reg && (w_reg == '0);
            end
            default:
            begin
                out_char_next = CH_ZERO;
                final_char    = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        w_next     = w_reg;
        d_next     = d_reg;
        ovf_next   = ovf_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (conv_done)
                    state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                // Fix the digit count and overflow, pick the first character
                if (dc_reg[4])
                    d_next = (sig > MAX_D) ? MAX_D : sig;
                else if (dc_reg[3:0] == 4'd0)
                    d_next = 4'd1;
                else
                    d_next = (dc_reg[3:0] > MAX_D) ? MAX_D : dc_reg[3:0];
                ovf_next = 1'b0;
                for (int i = 0; i < NUM_BCD; i++)
                begin
                    if ((4'(i) >= d_next) && (digits[i] != 4'd0))
                        ovf_next = 1'b1;
                end
                if (right_reg)
                begin
                    w_next     = '0;
                    phase_next = (!pp_reg[4] && (pp_reg[3:0] == 4'd0)) ? PH_POINT
                                                                       : PH_DIGIT;
                end
                else
                begin
                    w_next     = WGT_W'(d_next - 4'd1);
                    phase_next = (neg_reg || plus_reg) ? PH_SIGN : PH_DIGIT;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    col_next = right_reg ? col_reg - 7'd1 : col_reg + 7'd1;
                    if (final_char)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_SIGN:
                            begin
                                phase_next = PH_DIGIT;
                            end
                            PH_DIGIT:
                            begin
                                if (right_reg)
                                begin
                                    if (w_reg == lead_w)
                                    begin
                                        phase_next = PH_SIGN;
                                    end
                                    else
                                    begin
                                        w_next = w_reg + 1'b1;
                                        phase_next = (!pp_reg[4] &&
                                            (pp_reg[3:0] == 4'(w_reg + 1'b1)))
                                            ? PH_POINT : PH_DIGIT;
                                    end
                                end
                                else if (pp_hit)
                                begin
                                    phase_next = PH_POINT;
                                end
                                else
                                begin
                                    w_next = w_reg - 1'b1;
                                end
                            end
                            PH_POINT:
                            begin
                                phase_next = PH_DIGIT;
                                if (!right_reg)
                                    w_next = w_reg - 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_DIGIT;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: hold until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = final_char;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item fields and working registers
    always_ff @(posedge clk)
    begin
        phase_reg    <= phase_next;
        w_reg        <= w_next;
        d_reg        <= d_next;
        ovf_reg      <= ovf_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            neg_reg   <= raw[MAG_W-1];
            dc_reg    <= s_axis_tdata[36:32];
            pp_reg    <= s_axis_tdata[41:37];
            right_reg <= s_axis_tdata[42];
            plus_reg  <= s_axis_tdata[43];
            row_reg   <= s_axis_tdata[44];
            col_reg   <= {1'b0, s_axis_tdata[50:45]};
        end
        else
        begin
            col_reg <= col_next;
        end
        // Capture the whole beat so a new item cannot disturb a waiting one
        if (load)
        begin
            out_char_reg  <= out_char_next;
            out_col_reg   <= col_reg;
            out_row_reg   <= row_reg;
            out_width_reg <= width_rep;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_width_reg, out_col_reg, out_row_reg, out_char_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

// ===== verif/decimal_number_formatter_test.sv =====
`timescale 1ns / 1ps

module decimal_number_formatter_test
    import dnf_pkg::*;
;

    localparam int DIGITS_MAX   = 10;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [31:0] value;
        logic signed [4:0]  digit_count;
        logic signed [4:0]  point_position;
        logic               right_align;
        logic               show_plus;
        logic               start_row;
        logic        [5:0]  start_column;
    } num_item_t;

    // One row of the directed table; typed rows carry their single character
    typedef struct {
        num_item_t  item;
        logic       typed;
        logic [7:0] ch;
        logic [3:0] width;
        logic       ovf;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       row;
        logic [6:0] column;
        logic       last;
        logic [3:0] width;
        logic       ovf;
    } char_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    logic        gaps_on = 1'b1;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    char_beat_t  pending_chars [$];

    decimal_number_formatter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Directed cases: zero, saturation, point beyond the digits, sign rules, column wrap
    stim_row_t directed_rows [24] = '{
        '{'{32'sd0, -5'sd1, -5'sd1, 1'b0, 1'b0, 1'b0, 6'd0}, 1'b1, CH_ZERO, 4'd1, 1'b0},
        '{'{32'sd0, 5'sd0, -5'sd1, 1'b0, 1'b0, 1'b1, 6'd17}, 1'b1, CH_ZERO, 4'd1, 1'b0},
        '{'{32'sd7, 5'sd1, -5'sd1, 1'b1, 1'b0, 1'b1, 6'd39}, 1'b1, CH_ZERO + 8'd7, 4'd1, 1'b0},
        '{'{32'sd12, 5'sd1, -5'sd1, 1'b0, 1'b0, 1'b0, 6'd2}, 1'b1, CH_NINE, 4'd1, 1'b1},
        '{'{32'sh7fff_ffff, 5'sd1, -5'sd1, 1'b1, 1'b0, 1'b0, 6'd5}, 1'b1, CH_NINE, 4'd1, 1'b1},
        '{'{32'sd4, 5'sd1, 5'sd3, 1'b0, 1'b0, 1'b1, 6'd8}, 1'b1, CH_ZERO + 8'd4, 4'd2, 1'b0},
        '{'{32'sd5, -5'sd1, -5'sd5, 1'b0, 1'b0, 1'b0, 6'd1}, 1'b1, CH_ZERO + 8'd5, 4'd1, 1'b0},
        '{'{32'sd9, 5'sh10, 5'sh10, 1'b1, 1'b1, 1'b0, 6'd12}, 1'b1, CH_NINE, 4'd1, 1'b0},
        '{'{32'sd0, -5'sd1, -5'sd1, 1'b0, 1'b1, 1'b0, 6'd4}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sd0, -5'sd1, -5'sd1, 1'b1, 1'b1, 1'b1, 6'd6}, 1'b1, CH_ZERO, 4'd1, 1'b0},
        '{'{32'sh8000_0000, -5'sd1, -5'sd1, 1'b0, 1'b1, 1'b0, 6'd0}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sh8000_0000, -5'sd1, 5'sd9, 1'b1, 1'b0, 1'b1, 6'd39}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sh7fff_ffff, -5'sd1, 5'sd0, 1'b0, 1'b1, 1'b0, 6'd28}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sh7fff_ffff, 5'sd10, -5'sd1, 1'b1, 1'b0, 1'b0, 6'd0}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sd12345, 5'sd15, 5'sd4, 1'b0, 1'b0, 1'b1, 6'd3}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sd12345, 5'sh10, 5'sd2, 1'b1, 1'b0, 1'b0, 6'd63}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{-32'sd1, 5'sd10, 5'sd9, 1'b0, 1'b0, 1'b1, 6'd63}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sd999999999, -5'sd1, -5'sd1, 1'b0, 1'b0, 1'b0, 6'd0}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sd1000000000, -5'sd1, 5'sd5, 1'b1, 1'b0, 1'b0, 6'd30}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{-32'sd999, 5'sd2, -5'sd1, 1'b1, 1'b0, 1'b1, 6'd9}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sd42, 5'sd5, 5'sd15, 1'b0, 1'b0, 1'b0, 6'd11}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{-32'sd5, 5'sd3, 5'sd1, 1'b1, 1'b0, 1'b1, 6'd20}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sd100, 5'sd3, 5'sd0, 1'b0, 1'b1, 1'b0, 6'd10}, 1'b0, 8'd0, 4'd0, 1'b0},
        '{'{32'sh7fff_ffff, 5'sd15, 5'sd15, 1'b0, 1'b1, 1'b1, 6'd63}, 1'b0, 8'd0, 4'd0, 1'b0}
    };

    // Free-running clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        // keep the log short when the block is badly broken
        if (mismatch_count <= 50)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++)
            p = p * 10;
        return p;
    endfunction

    function automatic void queue_char(input logic [7:0] ch, input logic row, input int column,
                                       input logic last, input logic [3:0] width,
                                       input logic ovf);
        char_beat_t beat;
        beat = '{ch, row, 7'(column), last, width, ovf};
        pending_chars.push_back(beat);
    endfunction

    // Work out every character of one number, in output order
    function automatic void format_number(input num_item_t it);
        logic            neg;
        logic [31:0]     absval;
        longint unsigned mag, rem, q;
        int              dc, pp, d, cnt, col, pos, w;
        logic [7:0]      digits [0:10];
        logic [3:0]      width;
        logic            ovf;

        neg    = it.value[31];
        absval = neg ? (~it.value + 32'd1) : it.value;
        mag    = {32'b0, absval};
        dc     = int'(it.digit_count);
        pp     = int'(it.point_position);
        col    = int'(it.start_column);

        // size the digit field: automatic for any negative count, clamp the rest
        if (dc < 0)
        begin
            d = 1;
            while (d < DIGITS_MAX && mag >= pow10(d))
                d++;
        end
        else if (dc == 0)
            d = 1;
        else
            d = (dc > DIGITS_MAX) ? DIGITS_MAX : dc;
        ovf = (mag >= pow10(d));

        // digits from the top weight down; an oversized leading quotient shows as nine
        cnt = 0;
        rem = mag;
        for (w = d - 1; w >= 0; w--)
        begin
            q   = rem / pow10(w);
            rem = rem % pow10(w);
            if (q > 9)
                q = 9;
            digits[cnt] = CH_ZERO + 8'(q);
            cnt++;
            if (w == pp)
            begin
                digits[cnt] = CH_POINT;
                cnt++;
            end
        end
        width = 4'(d + ((pp >= 0) ? 1 : 0));

        if (!it.right_align)
        begin
            pos = col;
            if (neg)
            begin
                queue_char(CH_MINUS, it.start_row, pos, 1'b0, width, ovf);
                pos++;
            end
            else if (it.show_plus)
            begin
                queue_char(CH_PLUS, it.start_row, pos, 1'b0, width, ovf);
                pos++;
            end
            for (int i = 0; i < cnt; i++)
                queue_char(digits[i], it.start_row, pos + i, i == cnt - 1, width, ovf);
        end
        else
        begin
            for (int i = cnt - 1; i >= 0; i--)
                queue_char(digits[i], it.start_row, col - (cnt - 1 - i), i == 0 && !neg,
                           width, ovf);
            if (neg)
                queue_char(CH_MINUS, it.start_row, col - cnt, 1'b1, width, ovf);
        end
    endfunction

    function automatic num_item_t random_item();
        num_item_t       it;
        longint unsigned mag;
        int              sel;

        sel = $urandom_range(99);
        if (sel < 10)
            it.value = $urandom;
        else if (sel < 18)
        begin
            case ($urandom_range(5))
                0: it.value = 32'sh8000_0000;
                1: it.value = 32'sh7fff_ffff;
                2: it.value = 32'sd0;
                3: it.value = -32'sd1;
                4: it.value = 32'(pow10($urandom_range(0, 9)));
                default: it.value = -32'(pow10($urandom_range(0, 9)) - 1);
            endcase
        end
        else
        begin
            // spread magnitudes evenly over digit lengths
            mag = longint'($urandom) % pow10($urandom_range(1, 10));
            it.value = $urandom_range(1) ? -32'(mag) : 32'(mag);
        end

        it.digit_count    = ($urandom_range(99) < 75) ? 5'($urandom_range(0, 11) - 1)
                                                      : 5'($urandom);
        it.point_position = ($urandom_range(99) < 75) ? 5'($urandom_range(0, 10) - 1)
                                                      : 5'($urandom);
        it.right_align    = $urandom_range(1);
        it.show_plus      = $urandom_range(1);
        it.start_row      = $urandom_range(1);
        it.start_column   = ($urandom_range(99) < 85) ? 6'($urandom_range(0, 39))
                                                      : 6'($urandom);
        return it;
    endfunction

    // Present one number, hold it until taken, then log what it should print
    task automatic offer_number(input stim_row_t r);
        char_beat_t beat;

        while (gaps_on && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, r.item.start_column, r.item.start_row, r.item.show_plus,
                     r.item.right_align, r.item.point_position, r.item.digit_count,
                     r.item.value};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (r.typed)
        begin
            beat = '{r.ch, r.item.start_row, 7'(r.item.start_column), 1'b1, r.width, r.ovf};
            pending_chars.push_back(beat);
        end
        else
            format_number(r.item);
        @(negedge clk);
    endtask

    // Stall the output side at random
    always @(negedge clk)
    begin
        m_tready <= !(gaps_on && $urandom_range(99) < 7);
    end

    // Compare each output beat with the oldest expected character
    always @(posedge clk)
    begin : check_output
        char_beat_t got, want;

        if (rst_n && m_axis_tvalid && m_tready)
        begin
            got = '{m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[15:9], m_axis_tlast,
                    m_axis_tdata[19:16], m_axis_tuser};
            if (pending_chars.size() == 0)
                flag_mismatch($sformatf("unexpected char 0x%02h", got.ch));
            else
            begin
                want = pending_chars.pop_front();
                if (got.ch !== want.ch)
                    flag_mismatch($sformatf("char 0x%02h, want 0x%02h", got.ch, want.ch));
                if (got.row !== want.row)
                    flag_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
                if (got.column !== want.column)
                    flag_mismatch($sformatf("column %0d, want %0d",
                                            $signed(got.column), $signed(want.column)));
                if (got.last !== want.last)
                    flag_mismatch($sformatf("tlast %0b, want %0b", got.last, want.last));
                if (got.width !== want.width)
                    flag_mismatch($sformatf("width %0d, want %0d", got.width, want.width));
                if (got.ovf !== want.ovf)
                    flag_mismatch($sformatf("overflow %0b, want %0b", got.ovf, want.ovf));
            end
        end
    end

    initial
    begin
        stim_row_t r;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer_number(directed_rows[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // long stretch at full rate on both sides
            gaps_on = !(n >= 140 && n < 220);
            r = '{random_item(), 1'b0, 8'd0, 4'd0, 1'b0};
            offer_number(r);
        end
        s_tvalid <= 1'b0;
        gaps_on = 1'b1;

        // drain, then watch for stray beats
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== decimal_number_formatter.f =====
design/dnf_pkg.sv
design/dnf_bcd_conv.sv
design/decimal_number_formatter.sv
verif/decimal_number_formatter_test.sv
